[rtl/acl_pkg.sv]
// Package for the IPv4 allow/deny rule matcher.
// Holds the table sizes, octet test codes, verdict codes, queue entry type and the test function.
// No dependencies.
package acl_pkg;

  localparam int RULE_COUNT  = 16;
  localparam int RULE_IDX_W  = 4;                        // fixed by the rule_index field
  localparam int RULE_CNT_W  = $clog2(RULE_COUNT + 1);
  localparam int OCTET_COUNT = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_ANY    = 3'd0,
    OP_EQ     = 3'd1,
    OP_GE     = 3'd2,
    OP_GT     = 3'd3,
    OP_LE     = 3'd4,
    OP_LT     = 3'd5,
    OP_NE     = 3'd6,
    OP_MASKED = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_ALLOW   = 2'd0,
    VERDICT_DENY    = 2'd1,
    VERDICT_DEFAULT = 2'd2,
    VERDICT_WRITE   = 2'd3
  } verdict_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_CHECK = 1'b1
  } req_e;

  // One octet test, 20 bits: op, value, mask.
  typedef struct packed {
    op_e        op;
    logic [8:0] val;
    logic [7:0] msk;
  } test_t;

  typedef struct packed {
    logic deny;
    logic en;
  } flags_t;

  // Classified transaction held between front and back.
  typedef struct packed {
    logic                  is_check;
    logic [RULE_IDX_W-1:0] idx;
    logic [1:0]            pos;
    test_t                 test;
    flags_t                flags;
    logic [31:0]           addr;
  } q_entry_t;

  function automatic logic test_pass(test_t t, logic [7:0] oct);
    logic [8:0] oct9;
    logic       res;
    oct9 = {1'b0, oct};
    case (t.op)
      OP_EQ:     res = (oct9 == t.val);
      OP_GE:     res = (oct9 >= t.val);
      OP_GT:     res = (oct9 >  t.val);
      OP_LE:     res = (oct9 <= t.val);
      OP_LT:     res = (oct9 <  t.val);
      OP_NE:     res = (oct9 != t.val);
      OP_MASKED: res = ((t.val[7:0] & t.msk) == (oct & t.msk));
      default:   res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

[rtl/acl_if.sv]
// Valid/ready channel interfaces for the rule matcher: request and response.
// Depends on nothing; field widths follow the block's item definitions.
interface acl_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  rule_index;
  logic [1:0]  octet_position;
  logic [2:0]  octet_op;
  logic [8:0]  octet_value;
  logic [7:0]  octet_mask;
  logic        rule_enable;
  logic        rule_is_deny;
  logic [31:0] address;

  modport source (output valid, req_type, rule_index, octet_position, octet_op, octet_value,
                  octet_mask, rule_enable, rule_is_deny, address, input ready);
  modport sink   (input valid, req_type, rule_index, octet_position, octet_op, octet_value,
                  octet_mask, rule_enable, rule_is_deny, address, output ready);
endinterface

interface acl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [3:0] matched_rule;

  modport source (output valid, verdict, matched_rule, input ready);
  modport sink   (input valid, verdict, matched_rule, output ready);
endinterface

[rtl/ipv4_allow_deny_rule_matcher.sv]
// IPv4 allow/deny rule matcher, top level. Depends on acl_pkg, acl_if, acl_front, acl_back.
// Throughput: one write per cycle while the back end is idle and responses are taken; a check
// holds the back end until its scan, which reads one rule a cycle from the single read port
// of the rule store, is done and its verdict is loaded into the response register.
// Reset (rst_ni, async, active low): queue empty, scan idle, every rule disabled; the octet
// test store is not cleared and holds garbage until written.
module ipv4_allow_deny_rule_matcher
  import acl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  acl_req_if.sink    req_i,
  acl_rsp_if.source  rsp_o
);

  // Queue head between front and back. The front keeps accepting transactions into the
  // queue, until it is full, while the back scans or while a response waits to be taken.
  q_entry_t q_head;
  logic     q_valid;
  logic     q_pop;

  acl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_head_o  (q_head),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  // The back end applies writes to the rule store and checks by walking the rule table,
  // keeping the lowest matching allow and deny index; allow wins over deny.
  acl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_head_i  (q_head),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // Writes and default accepts report rule zero.
  a_rule_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && ((rsp_o.verdict == VERDICT_WRITE) || (rsp_o.verdict == VERDICT_DEFAULT))
      |-> (rsp_o.matched_rule == '0))
    else $error("nonzero rule index without a deciding rule");

  // A popped check cannot produce a response in the next cycle.
  a_check_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && q_head.is_check |=> !(rsp_o.valid && !$past(rsp_o.valid)))
    else $error("check answered without scanning");

endmodule

[rtl/acl_front.sv]
// Front end: accepts request transactions, classifies them and holds them in a short queue.
// Depends on acl_pkg and acl_req_if.
module acl_front
  import acl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  acl_req_if.sink    req_i,
  output q_entry_t   q_head_o,
  output logic       q_valid_o,
  input  logic       q_pop_i
);

  q_entry_t            q_mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  q_entry_t            entry;
  logic                push;
  logic                pop;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign req_i.ready = (cnt_q != CNT_FULL);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = q_pop_i && (cnt_q != '0);

  always_comb begin
    entry.is_check   = (req_i.req_type == REQ_CHECK);
    entry.idx        = req_i.rule_index;
    entry.pos        = req_i.octet_position;
    entry.test.op    = op_e'(req_i.octet_op);
    entry.test.val   = req_i.octet_value;
    entry.test.msk   = req_i.octet_mask;
    entry.flags.en   = req_i.rule_enable;
    entry.flags.deny = req_i.rule_is_deny;
    entry.addr       = req_i.address;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= entry;
    end
  end

  assign q_head_o  = q_mem_q[rd_ptr_q];
  assign q_valid_o = (cnt_q != '0);

endmodule

[rtl/acl_back.sv]
// Back end: rule store, one-rule-per-cycle scan and the response output register.
// Depends on acl_pkg and acl_rsp_if.
module acl_back
  import acl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_entry_t   q_head_i,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  acl_rsp_if.source  rsp_o
);

  typedef enum logic [2:0] {
    BE_IDLE = 3'b001,
    BE_SCAN = 3'b010,
    BE_OUT  = 3'b100
  } be_state_e;

  localparam logic [RULE_CNT_W-1:0] SCAN_END = RULE_CNT_W'(RULE_COUNT);

  be_state_e             state_q, state_d;
  test_t                 test_mem_q [OCTET_COUNT][RULE_COUNT];
  test_t                 rd_q       [OCTET_COUNT];
  flags_t                flags_q    [RULE_COUNT];
  flags_t                ev_flags_q;
  logic                  ev_vld_q;
  logic [RULE_IDX_W-1:0] ev_idx_q;
  logic [RULE_CNT_W-1:0] cnt_q;
  logic [31:0]           addr_q;
  logic                  allow_hit_q, deny_hit_q;
  logic [RULE_IDX_W-1:0] allow_idx_q, deny_idx_q;
  logic                  out_valid_q;
  verdict_e              out_verdict_q;
  logic [RULE_IDX_W-1:0] out_rule_q;

  logic                  out_free;
  logic                  start_write, start_check, wr_en;
  logic                  rd_en, scan_done, finish;
  logic [OCTET_COUNT-1:0] oct_pass;
  logic                  match;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign start_write = (state_q == BE_IDLE) && q_valid_i && !q_head_i.is_check && out_free;
  assign start_check = (state_q == BE_IDLE) && q_valid_i && q_head_i.is_check;
  assign q_pop_o     = start_write || start_check;
  assign wr_en       = start_write && (32'(q_head_i.idx) < RULE_COUNT);
  assign rd_en       = (state_q == BE_SCAN) && (cnt_q != SCAN_END);
  assign scan_done   = (state_q == BE_SCAN) && (cnt_q == SCAN_END) && !ev_vld_q;
  assign finish      = (state_q == BE_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE: if (start_check) state_d = BE_SCAN;
      BE_SCAN: if (scan_done) state_d = BE_OUT;
      BE_OUT:  if (finish) state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  // Octet test memories: one write port, one registered read port each.
  for (genvar g = 0; g < OCTET_COUNT; g++) begin : g_oct
    always_ff @(posedge clk_i) begin
      if (wr_en && (32'(q_head_i.pos) == g)) begin
        test_mem_q[g][q_head_i.idx] <= q_head_i.test;
      end
      if (rd_en) begin
        rd_q[g] <= test_mem_q[g][cnt_q[RULE_IDX_W-1:0]];
      end
    end
    assign oct_pass[g] = test_pass(rd_q[g], addr_q[31-8*g -: 8]);
  end

  assign match = ev_vld_q && ev_flags_q.en && (&oct_pass);

  always_ff @(posedge clk_i) begin
    if (start_check) begin
      addr_q <= q_head_i.addr;
    end
    if (rd_en) begin
      ev_flags_q <= flags_q[cnt_q[RULE_IDX_W-1:0]];
      ev_idx_q   <= cnt_q[RULE_IDX_W-1:0];
    end
    if (match && !ev_flags_q.deny && !allow_hit_q) begin
      allow_idx_q <= ev_idx_q;
    end
    if (match && ev_flags_q.deny && !deny_hit_q) begin
      deny_idx_q <= ev_idx_q;
    end
    if (start_write) begin
      out_verdict_q <= VERDICT_WRITE;
      out_rule_q    <= '0;
    end else if (finish) begin
      if (allow_hit_q) begin
        out_verdict_q <= VERDICT_ALLOW;
        out_rule_q    <= allow_idx_q;
      end else if (deny_hit_q) begin
        out_verdict_q <= VERDICT_DENY;
        out_rule_q    <= deny_idx_q;
      end else begin
        out_verdict_q <= VERDICT_DEFAULT;
        out_rule_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      cnt_q       <= '0;
      ev_vld_q    <= 1'b0;
      allow_hit_q <= 1'b0;
      deny_hit_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < RULE_COUNT; r++) begin
        flags_q[r] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ev_vld_q <= rd_en;
      if (wr_en) begin
        flags_q[q_head_i.idx] <= q_head_i.flags;
      end
      if (start_check) begin
        cnt_q       <= '0;
        allow_hit_q <= 1'b0;
        deny_hit_q  <= 1'b0;
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (match && !ev_flags_q.deny) begin
          allow_hit_q <= 1'b1;
        end
        if (match && ev_flags_q.deny) begin
          deny_hit_q <= 1'b1;
        end
      end
      if (start_write || finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.verdict      = out_verdict_q;
  assign rsp_o.matched_rule = out_rule_q;

endmodule

[tb/sv/tb_ipv4_allow_deny_rule_matcher.sv]
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_allow_deny_rule_matcher.
// Depends on acl_pkg, acl_if and the RTL; verdicts are predicted in a class and checked in order.
module tb_ipv4_allow_deny_rule_matcher;
  import acl_pkg::*;

  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 30;   // extra wait after every owed verdict is back

  // One request transaction as seen on the request channel.
  typedef struct packed {
    req_e        kind;
    logic [3:0]  idx;
    logic [1:0]  pos;
    op_e         op;
    logic [8:0]  val;
    logic [7:0]  msk;
    logic        en;
    logic        deny;
    logic [31:0] addr;
  } acl_item_t;

  typedef struct {
    verdict_e   verdict;
    logic [3:0] rule;
  } verdict_exp_t;

  // Shadow rule table plus the in-order queue of verdicts still owed by the block.
  class verdict_tracker;
    test_t        tests[RULE_COUNT][OCTET_COUNT];
    bit           written[RULE_COUNT][OCTET_COUNT];
    bit           enabled[RULE_COUNT];
    bit           deny_flag[RULE_COUNT];
    verdict_exp_t owed[$];
    int           errors;

    function new();
      foreach (tests[r, p]) begin
        tests[r][p] = '0;
        written[r][p] = 1'b0;
      end
      foreach (enabled[r]) begin
        enabled[r] = 1'b0;
        deny_flag[r] = 1'b0;
      end
      errors = 0;
    endfunction

    function bit octet_ok(test_t t, logic [7:0] oct);
      logic [8:0] wide;
      wide = {1'b0, oct};
      case (t.op)
        OP_EQ:     return wide == t.val;
        OP_GE:     return wide >= t.val;
        OP_GT:     return wide > t.val;
        OP_LE:     return wide <= t.val;
        OP_LT:     return wide < t.val;
        OP_NE:     return wide != t.val;
        OP_MASKED: return ((t.val[7:0] ^ oct) & t.msk) == 8'd0;
        default:   return 1'b1;
      endcase
    endfunction

    function bit rule_hit(int r, logic [31:0] addr);
      for (int p = 0; p < OCTET_COUNT; p++)
        if (!octet_ok(tests[r][p], addr[31-8*p -: 8])) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(acl_item_t it);
      verdict_exp_t e;
      bit           allow_seen;
      bit           deny_seen;
      int           allow_idx;
      int           deny_idx;
      allow_seen = 1'b0;
      deny_seen  = 1'b0;
      allow_idx  = 0;
      deny_idx   = 0;
      if (it.kind == REQ_WRITE) begin
        tests[it.idx][it.pos].op  = it.op;
        tests[it.idx][it.pos].val = it.val;
        tests[it.idx][it.pos].msk = it.msk;
        written[it.idx][it.pos] = 1'b1;
        enabled[it.idx]   = it.en;
        deny_flag[it.idx] = it.deny;
        e.verdict = VERDICT_WRITE;
        e.rule    = 4'd0;
      end else begin
        for (int r = 0; r < RULE_COUNT; r++) begin
          if (enabled[r] && rule_hit(r, it.addr)) begin
            if (!deny_flag[r] && !allow_seen) begin
              allow_seen = 1'b1;
              allow_idx  = r;
            end else if (deny_flag[r] && !deny_seen) begin
              deny_seen = 1'b1;
              deny_idx  = r;
            end
          end
        end
        // allow list wins over deny list regardless of index
        if (allow_seen) begin
          e.verdict = VERDICT_ALLOW;
          e.rule    = 4'(allow_idx);
        end else if (deny_seen) begin
          e.verdict = VERDICT_DENY;
          e.rule    = 4'(deny_idx);
        end else begin
          e.verdict = VERDICT_DEFAULT;
          e.rule    = 4'd0;
        end
      end
      owed.push_back(e);
    endfunction

    function void check_verdict(logic [1:0] verdict, logic [3:0] rule);
      verdict_exp_t e;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: response with nothing pending, got verdict %0d rule %0d",
                 $time, verdict, rule);
        return;
      end
      e = owed.pop_front();
      if (verdict !== e.verdict) begin
        errors++;
        $display("%0t: verdict mismatch, expected %0d got %0d", $time, e.verdict, verdict);
      end
      if (rule !== e.rule) begin
        errors++;
        $display("%0t: matched_rule mismatch, expected %0d got %0d", $time, e.rule, rule);
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  acl_req_if req ();
  acl_rsp_if rsp ();

  ipv4_allow_deny_rule_matcher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  verdict_tracker sb = new();
  int             items_sent = 0;
  int             cycle_count = 0;
  bit             req_calm = 1'b0;   // when set the sender adds no idle gap after an item

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Gap / stall length: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Comparison constants: mostly octet range, some saturated-range values, some extremes.
  function automatic logic [8:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 9'($urandom_range(256, 511));
    if (r < 22) return ($urandom_range(0, 1) == 1) ? 9'd255 : 9'd0;
    return 9'($urandom_range(0, 255));
  endfunction

  function automatic acl_item_t make_write(int idx, int pos, op_e op, logic [8:0] val,
                                           logic [7:0] msk, bit en, bit deny);
    acl_item_t it;
    it.kind = REQ_WRITE;
    it.idx  = 4'(idx);
    it.pos  = 2'(pos);
    it.op   = op;
    it.val  = val;
    it.msk  = msk;
    it.en   = en;
    it.deny = deny;
    it.addr = $urandom;   // ignored on writes
    return it;
  endfunction

  // Check transaction; the write-only fields carry junk.
  function automatic acl_item_t make_check(logic [31:0] addr);
    acl_item_t it;
    it = make_write($urandom_range(0, 15), $urandom_range(0, 3), op_e'($urandom_range(0, 7)),
                    9'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    it.kind = REQ_CHECK;
    it.addr = addr;
    return it;
  endfunction

  // Address built around one rule's constants so that checks actually hit rules.
  function automatic logic [31:0] aim_address();
    logic [31:0] a;
    test_t       t;
    logic [7:0]  o;
    int          r;
    r = $urandom_range(0, RULE_COUNT - 1);
    a = $urandom;
    for (int p = 0; p < OCTET_COUNT; p++) begin
      t = sb.tests[r][p];
      case ($urandom_range(0, 4))
        0:       o = t.val[7:0];
        1:       o = t.val[7:0] + 8'd1;
        2:       o = t.val[7:0] - 8'd1;
        3:       o = (t.val[7:0] & t.msk) | (8'($urandom) & ~t.msk);
        default: o = 8'($urandom);
      endcase
      a[31-8*p -: 8] = o;
    end
    return a;
  endfunction

  task automatic drive_fields(acl_item_t it);
    req.req_type       <= it.kind;
    req.rule_index     <= it.idx;
    req.octet_position <= it.pos;
    req.octet_op       <= it.op;
    req.octet_value    <= it.val;
    req.octet_mask     <= it.msk;
    req.rule_enable    <= it.en;
    req.rule_is_deny   <= it.deny;
    req.address        <= it.addr;
  endtask

  // Valid low with junk payload while idling.
  task automatic idle(int n);
    acl_item_t junk;
    junk = make_check($urandom);
    junk.kind = req_e'($urandom_range(0, 1));
    req.valid <= 1'b0;
    drive_fields(junk);
    repeat (n) @(posedge clk_i);
  endtask

  // Present one transaction, hold until accepted, then maybe idle. Valid stays high on
  // return when there is no gap, so back-to-back transactions never toggle it in one step.
  task automatic push_item(acl_item_t it);
    int gap;
    req.valid <= 1'b1;
    drive_fields(it);
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(it);
    items_sent++;
    if ($urandom_range(0, 99) == 0) req_calm = !req_calm;
    gap = 0;
    if (!req_calm && $urandom_range(0, 1) == 1) gap = gap_len();
    if (gap > 0) idle(gap);
  endtask

  // Hold off until every owed verdict is back.
  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Octet tests of enabled rules are undefined until written; complete any such rule
  // before a check may scan it.
  task automatic fill_missing();
    for (int r = 0; r < RULE_COUNT; r++)
      for (int p = 0; p < OCTET_COUNT; p++)
        if (sb.enabled[r] && !sb.written[r][p])
          push_item(make_write(r, p, op_e'($urandom_range(0, 7)), rand_value(), 8'($urandom),
                               1'b1, sb.deny_flag[r]));
  endtask

  // Well-formed rule load: all four octets of one slot, in a rotated order, same flags.
  task automatic program_rule();
    int   idx;
    int   first;
    bit   en;
    bit   deny;
    op_e  op;
    idx   = $urandom_range(0, RULE_COUNT - 1);
    first = $urandom_range(0, 3);
    en    = ($urandom_range(0, 5) != 0);
    deny  = 1'($urandom);
    for (int k = 0; k < OCTET_COUNT; k++) begin
      // lean on "any" so that rules match often enough to matter
      op = ($urandom_range(0, 9) < 4) ? OP_ANY : op_e'($urandom_range(0, 7));
      push_item(make_write(idx, (first + k) % OCTET_COUNT, op, rand_value(), 8'($urandom),
                           en, deny));
    end
  endtask

  // Checks: aimed at a rule, fully random, or an extreme address.
  task automatic random_check();
    int          r;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    if (r < 60)      a = aim_address();
    else if (r < 95) a = $urandom;
    else             a = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    fill_missing();
    push_item(make_check(a));
  endtask

  // Response side: random ready with long and short stalls and calm stretches.
  initial begin
    int   stall_left;
    bit   calm;
    logic nxt;
    stall_left = 0;
    calm       = 1'b0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp.valid && rsp.ready) sb.check_verdict(rsp.verdict, rsp.matched_rule);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      rsp.ready <= nxt;
    end
  end

  // Stimulus: reset, directed cases, then the random mix.
  initial begin
    int r;
    rst_ni    <= 1'b0;
    req.valid <= 1'b0;
    drive_fields(make_check(32'h0));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every rule disabled after reset: accepted by default
    push_item(make_check(32'h0000_0000));

    // allow rule 5: 192 . >=168 . <10 . !=1
    push_item(make_write(5, 0, OP_EQ, 9'd192, 8'h00, 1'b1, 1'b0));
    push_item(make_write(5, 1, OP_GE, 9'd168, 8'h00, 1'b1, 1'b0));
    push_item(make_write(5, 2, OP_LT, 9'd10,  8'h00, 1'b1, 1'b0));
    push_item(make_write(5, 3, OP_NE, 9'd1,   8'h00, 1'b1, 1'b0));
    push_item(make_check({8'd192, 8'd168, 8'd0, 8'd2}));
    push_item(make_check({8'd192, 8'd168, 8'd0, 8'd1}));

    // deny rule 2, masked first octet with bit 8 of the constant set (masked off)
    push_item(make_write(2, 0, OP_MASKED, 9'h1C0, 8'hF0, 1'b1, 1'b1));
    push_item(make_write(2, 1, OP_GT,     9'd100, 8'hFF, 1'b1, 1'b1));
    push_item(make_write(2, 2, OP_ANY,    9'd511, 8'hFF, 1'b1, 1'b1));
    push_item(make_write(2, 3, OP_ANY,    9'd0,   8'h00, 1'b1, 1'b1));
    // allow 5 beats the lower-index deny 2
    push_item(make_check({8'd192, 8'd200, 8'd0, 8'd2}));
    push_item(make_check({8'd193, 8'd101, 8'd7, 8'd7}));

    // deny rule 12 built from large constants: ne, le and lt always pass
    push_item(make_write(12, 0, OP_NE, 9'd300, 8'h00, 1'b1, 1'b1));
    push_item(make_write(12, 1, OP_LE, 9'd511, 8'h00, 1'b1, 1'b1));
    push_item(make_write(12, 2, OP_LT, 9'd256, 8'h00, 1'b1, 1'b1));
    push_item(make_write(12, 3, OP_GE, 9'd0,   8'h00, 1'b1, 1'b1));
    push_item(make_check(32'hFFFF_FFFF));

    // allow rule 9: large constants make eq, ge and gt fail, so it never matches
    push_item(make_write(9, 0, OP_EQ,  9'd300, 8'h00, 1'b1, 1'b0));
    push_item(make_write(9, 1, OP_GE,  9'd400, 8'h00, 1'b1, 1'b0));
    push_item(make_write(9, 2, OP_GT,  9'd256, 8'h00, 1'b1, 1'b0));
    push_item(make_write(9, 3, OP_ANY, 9'd0,   8'h00, 1'b1, 1'b0));
    push_item(make_check(32'h0A00_0000));

    // a single write with enable low turns rule 12 off again
    push_item(make_write(12, 3, OP_GE, 9'd0, 8'h00, 1'b0, 1'b1));
    push_item(make_check(32'h0A00_0000));

    drain();

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 25)      program_rule();
      else if (r < 40) push_item(make_write($urandom_range(0, 15), $urandom_range(0, 3),
                                            op_e'($urandom_range(0, 7)), rand_value(),
                                            8'($urandom), ($urandom_range(0, 3) != 0),
                                            1'($urandom)));
      else             random_check();
      if ($urandom_range(0, 299) == 0) drain();
    end

    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
